// ===== rtl/tmv_pkg.sv =====
`timescale 1ns / 1ps

package tmv_pkg;

  localparam int DefaultMaxOrder = 64;
  localparam int DefaultValueWidth = 32;
  localparam int IdxBits = 6;
  localparam int SizeBits = 7;
  localparam int FracBits = 16;
  localparam int OutWidth = 32;
  localparam int CfgDataBits = 7;
  localparam int CfgIndexBits = 2;

  typedef enum logic [1:0] {
    OP_LOAD_MATRIX = 2'd0,
    OP_LOAD_VECTOR = 2'd1,
    OP_COMPUTE     = 2'd2
  } opcode_e;

  typedef enum logic [CfgIndexBits-1:0] {
    CFG_USE_UPPER     = 2'd0,
    CFG_TRANSPOSE     = 2'd1,
    CFG_UNIT_DIAGONAL = 2'd2,
    CFG_SIZE_IN_USE   = 2'd3
  } cfg_index_e;

  // One multiply-accumulate step issued by the sequencer.
  typedef struct packed {
    logic               valid;
    logic [IdxBits-1:0] row;
    logic [IdxBits-1:0] col;
    logic               first;
    logic               last;
    logic               unit_diag;
    logic               last_row;
  } step_t;

endpackage

// ===== rtl/tmv_seq.sv =====
`timescale 1ns / 1ps

module tmv_seq (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         go_i,
  input  logic [tmv_pkg::SizeBits-1:0] n_i,
  input  logic                         upper_i,
  input  logic                         unit_i,
  input  logic                         done_i,
  output tmv_pkg::step_t               step_o,
  output logic                         busy_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_DRAIN
  } state_e;

  state_e                      state_q;
  logic [tmv_pkg::IdxBits-1:0] i_q;
  logic [tmv_pkg::IdxBits-1:0] j_q;
  logic [tmv_pkg::SizeBits-1:0] n_m1;
  logic                        row_last;
  logic                        step_last;
  logic                        step_first;

  always_comb begin
    n_m1 = n_i - tmv_pkg::SizeBits'(1);
    row_last = ({1'b0, i_q} == n_m1);
    if (upper_i) begin
      step_last = ({1'b0, j_q} == n_m1);
      step_first = (j_q == i_q);
    end else begin
      step_last = (j_q == i_q);
      step_first = (j_q == '0);
    end
    step_o.valid = (state_q == S_RUN);
    step_o.row = i_q;
    step_o.col = j_q;
    step_o.first = step_first;
    step_o.last = step_last;
    step_o.unit_diag = unit_i && (i_q == j_q);
    step_o.last_row = row_last;
  end

  assign busy_o = (state_q != S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      i_q <= '0;
      j_q <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (go_i) begin
            state_q <= S_RUN;
            i_q <= '0;
            j_q <= '0;
          end
        end
        S_RUN: begin
          if (step_last) begin
            if (row_last) begin
              state_q <= S_DRAIN;
            end else begin
              i_q <= i_q + tmv_pkg::IdxBits'(1);
              j_q <= upper_i ? i_q + tmv_pkg::IdxBits'(1) : '0;
            end
          end else begin
            j_q <= j_q + tmv_pkg::IdxBits'(1);
          end
        end
        S_DRAIN: begin
          if (done_i) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/tmv_mem.sv =====
`timescale 1ns / 1ps

module tmv_mem #(
  parameter int MAX_ORDER = tmv_pkg::DefaultMaxOrder,
  parameter int WIDTH = tmv_pkg::DefaultValueWidth
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         mat_we_i,
  input  logic                         vec_we_i,
  input  logic [((MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1)-1:0] ld_row_i,
  input  logic [((MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1)-1:0] ld_col_i,
  input  logic [WIDTH-1:0]             ld_data_i,
  input  logic                         transpose_i,
  input  tmv_pkg::step_t               step_i,
  input  logic                         wb_we_i,
  input  logic [((MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1)-1:0] wb_idx_i,
  input  logic [WIDTH-1:0]             wb_data_i,
  input  logic                         flip_i,
  input  logic [tmv_pkg::SizeBits-1:0] n_i,
  output logic signed [WIDTH-1:0]      a_o,
  output logic signed [WIDTH-1:0]      x_o
);

  localparam int IW = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
  localparam int Slots = 1 << IW;
  localparam int MatDepth = 1 << (2 * IW);
  localparam int VecDepth = 2 << IW;

  logic [WIDTH-1:0] mat_mem [MatDepth];
  logic [WIDTH-1:0] vec_mem [VecDepth];
  logic [Slots-1:0] sel_q;
  logic [IW-1:0]    rd_i;
  logic [IW-1:0]    rd_j;
  logic [2*IW-1:0]  mat_raddr;
  logic [2*IW-1:0]  mat_waddr;
  logic [IW:0]      vec_raddr;
  logic [IW:0]      vec_waddr;
  logic [Slots-1:0] flip_mask;

  always_comb begin
    rd_i = step_i.row[IW-1:0];
    rd_j = step_i.col[IW-1:0];
    mat_raddr = transpose_i ? {rd_j, rd_i} : {rd_i, rd_j};
    mat_waddr = {ld_row_i, ld_col_i};
    vec_raddr = {sel_q[rd_j], rd_j};
    if (wb_we_i) begin
      vec_waddr = {~sel_q[wb_idx_i], wb_idx_i};
    end else begin
      vec_waddr = {sel_q[ld_row_i], ld_row_i};
    end
    for (int k = 0; k < Slots; k++) begin
      flip_mask[k] = (tmv_pkg::SizeBits'(k) < n_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (mat_we_i) begin
      mat_mem[mat_waddr] <= ld_data_i;
    end
    a_o <= mat_mem[mat_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (wb_we_i || vec_we_i) begin
      vec_mem[vec_waddr] <= wb_we_i ? wb_data_i : ld_data_i;
    end
    x_o <= vec_mem[vec_raddr];
  end

  // Each bit marks which bank holds the current vector element.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q <= '0;
    end else if (flip_i) begin
      sel_q <= sel_q ^ flip_mask;
    end
  end

endmodule

// ===== rtl/tmv_mac.sv =====
`timescale 1ns / 1ps

module tmv_mac #(
  parameter int WIDTH = tmv_pkg::DefaultValueWidth
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  tmv_pkg::step_t                      step_i,
  input  logic signed [WIDTH-1:0]             a_i,
  input  logic signed [WIDTH-1:0]             x_i,
  output logic                                valid_o,
  output logic [tmv_pkg::IdxBits-1:0]         index_o,
  output logic signed [tmv_pkg::OutWidth-1:0] value_o,
  output logic                                last_o
);

  localparam int PW = 2 * WIDTH;
  localparam int AW = PW + tmv_pkg::IdxBits + 1;
  localparam logic signed [AW-1:0] Half = AW'(1) << (tmv_pkg::FracBits - 1);
  localparam logic signed [AW-1:0] MaxVal = (AW'(1) << (WIDTH - 1)) - AW'(1);
  localparam logic signed [AW-1:0] MinVal = -MaxVal - AW'(1);

  tmv_pkg::step_t           s1_q;
  tmv_pkg::step_t           s2_q;
  tmv_pkg::step_t           s3_q;
  logic signed [PW-1:0]     prod_d;
  logic signed [PW-1:0]     prod_q;
  logic signed [AW-1:0]     prod_ext;
  logic signed [AW-1:0]     acc_d;
  logic signed [AW-1:0]     acc_q;
  logic signed [AW-1:0]     rounded;
  logic signed [WIDTH-1:0]  res_d;
  logic                     valid_q;
  logic [tmv_pkg::IdxBits-1:0] index_q;
  logic signed [tmv_pkg::OutWidth-1:0] value_q;
  logic                     last_q;

  always_comb begin
    if (s1_q.unit_diag) begin
      prod_d = {{(WIDTH - tmv_pkg::FracBits){x_i[WIDTH-1]}}, x_i,
                {tmv_pkg::FracBits{1'b0}}};
    end else begin
      prod_d = a_i * x_i;
    end
    prod_ext = {{(AW - PW){prod_q[PW-1]}}, prod_q};
    acc_d = s2_q.first ? prod_ext : acc_q + prod_ext;
    rounded = (acc_q + Half) >>> tmv_pkg::FracBits;
    if (rounded > MaxVal) begin
      res_d = MaxVal[WIDTH-1:0];
    end else if (rounded < MinVal) begin
      res_d = MinVal[WIDTH-1:0];
    end else begin
      res_d = rounded[WIDTH-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= '0;
      s2_q <= '0;
      s3_q <= '0;
      valid_q <= 1'b0;
    end else begin
      s1_q <= step_i;
      s2_q <= s1_q;
      s3_q <= s2_q;
      valid_q <= s3_q.valid && s3_q.last;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    if (s2_q.valid) begin
      acc_q <= acc_d;
    end
    if (s3_q.valid && s3_q.last) begin
      index_q <= s3_q.row;
      value_q <= tmv_pkg::OutWidth'(res_d);
      last_q <= s3_q.last_row;
    end
  end

  assign valid_o = valid_q;
  assign index_o = index_q;
  assign value_o = value_q;
  assign last_o = valid_q && last_q;

endmodule

// ===== rtl/triangular_matrix_vector_multiply.sv =====
`timescale 1ns / 1ps

// Port group   Signals                                        Direction
// command      start_i, busy_o, opcode_i, row_index_i,        in (busy_o out)
//              col_index_i, element_value_i
// result       result_valid_o, result_index_o,                out
//              result_value_o, last_element_o
// config       cfg_we_i, cfg_index_i, cfg_data_i              in
//
// A load word leaves busy_o low.
// A compute word of order n keeps busy_o high until its last result word: the single
// multiplier takes one triangle entry per cycle, behind a registered memory read.
// Result words leave one per row end, each for a single cycle, and cannot be stalled.
// Reset restores the register defaults; the matrix and vector stores are not cleared.

module triangular_matrix_vector_multiply #(
  parameter int MAX_ORDER = tmv_pkg::DefaultMaxOrder,
  parameter int VALUE_WIDTH = tmv_pkg::DefaultValueWidth
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic [1:0]                          opcode_i,
  input  logic [tmv_pkg::IdxBits-1:0]         row_index_i,
  input  logic [tmv_pkg::IdxBits-1:0]         col_index_i,
  input  logic signed [31:0]                  element_value_i,
  output logic                                result_valid_o,
  output logic [tmv_pkg::IdxBits-1:0]         result_index_o,
  output logic signed [tmv_pkg::OutWidth-1:0] result_value_o,
  output logic                                last_element_o,
  input  logic                                cfg_we_i,
  input  logic [tmv_pkg::CfgIndexBits-1:0]    cfg_index_i,
  input  logic [tmv_pkg::CfgDataBits-1:0]     cfg_data_i
);

  localparam int IW = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
  localparam int VW = (VALUE_WIDTH > 32) ? 32 : ((VALUE_WIDTH < 16) ? 16 : VALUE_WIDTH);
  localparam logic [tmv_pkg::SizeBits-1:0] OrderLimit = tmv_pkg::SizeBits'(MAX_ORDER);

  typedef struct packed {
    logic                         use_upper;
    logic                         transpose;
    logic                         unit_diagonal;
    logic [tmv_pkg::SizeBits-1:0] size_in_use;
  } cfg_t;

  cfg_t                         cfg_q;
  logic [tmv_pkg::SizeBits-1:0] n_eff;
  logic                         accept;
  logic                         row_ok;
  logic                         col_ok;
  logic                         mat_we;
  logic                         vec_we;
  logic                         go;
  logic                         seq_busy;
  tmv_pkg::step_t               step;
  logic signed [VW-1:0]         a_rd;
  logic signed [VW-1:0]         x_rd;
  logic                         res_valid;
  logic [tmv_pkg::IdxBits-1:0]  res_index;
  logic signed [tmv_pkg::OutWidth-1:0] res_value;
  logic                         res_last;
  logic                         done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.use_upper <= 1'b1;
      cfg_q.transpose <= 1'b0;
      cfg_q.unit_diagonal <= 1'b1;
      cfg_q.size_in_use <= tmv_pkg::SizeBits'(64);
    end else if (cfg_we_i) begin
      unique case (tmv_pkg::cfg_index_e'(cfg_index_i))
        tmv_pkg::CFG_USE_UPPER:     cfg_q.use_upper <= cfg_data_i[0];
        tmv_pkg::CFG_TRANSPOSE:     cfg_q.transpose <= cfg_data_i[0];
        tmv_pkg::CFG_UNIT_DIAGONAL: cfg_q.unit_diagonal <= cfg_data_i[0];
        tmv_pkg::CFG_SIZE_IN_USE:   cfg_q.size_in_use <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    n_eff = (cfg_q.size_in_use > OrderLimit) ? OrderLimit : cfg_q.size_in_use;
    accept = start_i && !seq_busy;
    row_ok = ({1'b0, row_index_i} < OrderLimit);
    col_ok = ({1'b0, col_index_i} < OrderLimit);
    mat_we = 1'b0;
    vec_we = 1'b0;
    go = 1'b0;
    unique case (tmv_pkg::opcode_e'(opcode_i))
      tmv_pkg::OP_LOAD_MATRIX: mat_we = accept && row_ok && col_ok;
      tmv_pkg::OP_LOAD_VECTOR: vec_we = accept && row_ok;
      tmv_pkg::OP_COMPUTE:     go = accept && (n_eff != '0);
      default: begin
      end
    endcase
  end

  assign done = res_valid && res_last;

  tmv_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .go_i    (go),
    .n_i     (n_eff),
    .upper_i (cfg_q.use_upper ^ cfg_q.transpose),
    .unit_i  (cfg_q.unit_diagonal),
    .done_i  (done),
    .step_o  (step),
    .busy_o  (seq_busy)
  );

  tmv_mem #(
    .MAX_ORDER (MAX_ORDER),
    .WIDTH     (VW)
  ) u_mem (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mat_we_i    (mat_we),
    .vec_we_i    (vec_we),
    .ld_row_i    (row_index_i[IW-1:0]),
    .ld_col_i    (col_index_i[IW-1:0]),
    .ld_data_i   (element_value_i[VW-1:0]),
    .transpose_i (cfg_q.transpose),
    .step_i      (step),
    .wb_we_i     (res_valid),
    .wb_idx_i    (res_index[IW-1:0]),
    .wb_data_i   (res_value[VW-1:0]),
    .flip_i      (done),
    .n_i         (n_eff),
    .a_o         (a_rd),
    .x_o         (x_rd)
  );

  tmv_mac #(
    .WIDTH (VW)
  ) u_mac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (step),
    .a_i     (a_rd),
    .x_i     (x_rd),
    .valid_o (res_valid),
    .index_o (res_index),
    .value_o (res_value),
    .last_o  (res_last)
  );

  assign busy_o = seq_busy;
  assign result_valid_o = res_valid;
  assign result_index_o = res_index;
  assign result_value_o = res_value;
  assign last_element_o = res_last;

  a_result_while_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> busy_o)
    else $error("result word outside a compute run");

  a_last_has_strobe : assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_element_o |-> result_valid_o)
    else $error("last marker without a result word");

  a_compute_goes_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && (opcode_i == tmv_pkg::OP_COMPUTE) && (n_eff != '0)) |=> busy_o)
    else $error("compute word did not start a run");

  a_last_ends_run : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && last_element_o) |=> !busy_o)
    else $error("run did not end after the last result word");

  a_step_idle_when_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_o |-> !step.valid)
    else $error("sequencer issues steps while idle");

endmodule
